// ===== rtl/spsc_pkg.sv =====
// shared types and constants for the sorted pair sum counter
`default_nettype none
package spsc_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int COUNT_W      = 11;

	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_RUN      = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] element_value;
	} in_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pair_count;
		logic               overflow;
	} out_res_t;

	typedef struct packed {
		logic append_a;
		logic append_b;
		logic start;
		logic step;
		logic finish;
	} spsc_cmd_t;

	typedef struct packed {
		logic walk_done;
	} spsc_sts_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_pair_sum_counter_core.sv =====
// Top level of the sorted pair sum counter.
// Appends to A or B are accepted back to back.
// A run stalls requests while it walks the stores, one walk step per cycle
// (one read of each store per cycle), then while the result is registered, and while
// an earlier result is still held by out_stall; valid rises as stall drops.
// Reset clears lengths, overflow flag, target, walk pointers, count and control; the stores are not reset.
`default_nettype none
module sorted_pair_sum_counter_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire spsc_pkg::in_req_t                  in_req,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output spsc_pkg::out_res_t                      out_res,
	input  wire logic                               cfg_wr_en,
	input  wire logic signed [spsc_pkg::DATA_W-1:0] cfg_wr_data
);

	spsc_pkg::spsc_cmd_t cmd;
	spsc_pkg::spsc_sts_t sts;

	spsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (in_req.opcode),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	spsc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.element_value (in_req.element_value),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.sts           (sts),
		.res           (out_res)
	);

endmodule
`default_nettype wire

// ===== rtl/spsc_dp.sv =====
// datapath: element stores, lengths, walk pointers, compare and result register
`default_nettype none
module spsc_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire spsc_pkg::spsc_cmd_t                cmd,
	input  wire logic signed [spsc_pkg::DATA_W-1:0] element_value,
	input  wire logic                               cfg_wr_en,
	input  wire logic signed [spsc_pkg::DATA_W-1:0] cfg_wr_data,
	output spsc_pkg::spsc_sts_t                     sts,
	output spsc_pkg::out_res_t                      res
);

	logic [spsc_pkg::DATA_W-1:0]  mem_a [spsc_pkg::MAX_ELEMENTS];
	logic [spsc_pkg::DATA_W-1:0]  mem_b [spsc_pkg::MAX_ELEMENTS];
	logic [spsc_pkg::DATA_W-1:0]  rd_a_q, rd_b_q;
	logic [spsc_pkg::DATA_W-1:0]  target_q;
	logic [spsc_pkg::LEN_W-1:0]   len_a_q, len_b_q;
	logic [spsc_pkg::LEN_W-1:0]   i_q, j_q, i_n, j_n, jm1_n;
	logic [spsc_pkg::COUNT_W-1:0] count_q;
	logic                         dropped_q;
	spsc_pkg::out_res_t           res_q;
	logic                         full_a, full_b, wr_a, wr_b;
	logic signed [spsc_pkg::DATA_W:0] sum, k33;
	logic                         gt, lt;

	assign full_a = (len_a_q == spsc_pkg::LEN_W'(spsc_pkg::MAX_ELEMENTS));
	assign full_b = (len_b_q == spsc_pkg::LEN_W'(spsc_pkg::MAX_ELEMENTS));
	assign wr_a   = cmd.append_a && !full_a;
	assign wr_b   = cmd.append_b && !full_b;

	assign sum = $signed({rd_a_q[spsc_pkg::DATA_W-1], rd_a_q})
	           + $signed({rd_b_q[spsc_pkg::DATA_W-1], rd_b_q});
	assign k33 = $signed({target_q[spsc_pkg::DATA_W-1], target_q});
	assign gt  = sum > k33;
	assign lt  = sum < k33;

	assign sts.walk_done = (i_q >= len_a_q) || (j_q == '0);

	// next pointers drive the read addresses
	always_comb begin
		i_n = i_q;
		j_n = j_q;
		if (cmd.start) begin
			i_n = '0;
			j_n = len_b_q;
		end else if (cmd.step) begin
			i_n = i_q + spsc_pkg::LEN_W'(!gt);
			j_n = j_q - spsc_pkg::LEN_W'(!lt);
		end
		jm1_n = j_n - spsc_pkg::LEN_W'(1);
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[spsc_pkg::ADDR_W-1:0]] <= element_value;
		end
		rd_a_q <= mem_a[i_n[spsc_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[len_b_q[spsc_pkg::ADDR_W-1:0]] <= element_value;
		end
		rd_b_q <= mem_b[jm1_n[spsc_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			len_a_q   <= '0;
			len_b_q   <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			count_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (wr_a) begin
				len_a_q <= len_a_q + spsc_pkg::LEN_W'(1);
			end
			if (wr_b) begin
				len_b_q <= len_b_q + spsc_pkg::LEN_W'(1);
			end
			if ((cmd.append_a && full_a) || (cmd.append_b && full_b)) begin
				dropped_q <= 1'b1;
			end
			i_q <= i_n;
			j_q <= j_n;
			if (cmd.start) begin
				count_q <= '0;
			end else if (cmd.step && !gt && !lt) begin
				count_q <= count_q + spsc_pkg::COUNT_W'(1);
			end
			if (cmd.finish) begin
				len_a_q   <= '0;
				len_b_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.pair_count <= count_q;
			res_q.overflow   <= dropped_q;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

// ===== rtl/spsc_ctrl.sv =====
// controller: request handshake, walk sequencing and result valid
`default_nettype none
module spsc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          opcode,
	input  wire logic                out_stall,
	input  wire spsc_pkg::spsc_sts_t sts,
	output logic                     in_stall,
	output logic                     out_valid,
	output spsc_pkg::spsc_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept, can_load;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		cmd.append_a = accept && (opcode == spsc_pkg::OP_APPEND_A);
		cmd.append_b = accept && (opcode == spsc_pkg::OP_APPEND_B);
		cmd.start    = accept && (opcode == spsc_pkg::OP_RUN);
		cmd.step     = (state_q == ST_WALK) && !sts.walk_done;
		cmd.finish   = (state_q == ST_FINISH) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.walk_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
